### rtl/core/malc_pkg.sv
// ----------------------------------------------------------------------------
// malc_pkg
// Shared widths, register map and reset values for the moving average
// level classifier.
// ----------------------------------------------------------------------------
package malc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int LEVEL_W    = 3;
    localparam int THR_N      = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int DEF_WINDOW = 16;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [LEVEL_W-1:0]  t_level;

    typedef enum logic [1:0] {
        REG_THR1 = 2'd0,
        REG_THR2 = 2'd1,
        REG_THR3 = 2'd2,
        REG_THR4 = 2'd3
    } t_reg_idx;

    localparam t_sample THR1_RST = 12'd2110;
    localparam t_sample THR2_RST = 12'd2220;
    localparam t_sample THR3_RST = 12'd2330;
    localparam t_sample THR4_RST = 12'd2440;

    localparam t_level LEVEL_NONE = 3'd4;

endpackage

### rtl/core/moving_average_level_classifier.sv
// ----------------------------------------------------------------------------
// moving_average_level_classifier
// Boxcar moving average over the last WINDOW samples, with a level bucket
// from four programmable thresholds.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_sample
//   result    out        o_valid / i_ready   o_average, o_level
//   config    in         APB, pready tied    paddr, pwdata, prdata
//
// One sample per cycle sustained while i_ready keeps the output register free; a
// result passes from its input transfer through the ring read, running-sum
// update and reciprocal multiply, then is classified into the output register.
// The rate is set by the single ring read at the write position and the
// running-sum register, each used once per sample.
// Synchronous reset clears per-entry valid bits, so unwritten ring entries
// read as zero; no clearing pass is needed.
// Each stage holds while the next is full, so a sample is still taken while
// a finished result waits on the output register.
// ----------------------------------------------------------------------------
module moving_average_level_classifier
    import malc_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [11:0]       i_sample,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [11:0]       o_average,
    output logic [2:0]        o_level,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW  = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int LW  = $clog2(WINDOW);
    localparam int KSH = SW + LW;
    // exact reciprocal: floor(x/W) == (x*RECIP) >> KSH for every x below 2^SW
    localparam longint unsigned RECIP = ((64'd1 << KSH) / WINDOW) + 64'd1;
    localparam int MW  = $clog2(RECIP + 1);
    localparam int PRW = SW + MW;
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
    localparam logic [MW-1:0] W_RECIP  = MW'(RECIP);

    // sample ring
    t_sample         r_ring [WINDOW];
    logic [WINDOW-1:0] r_ring_vld;
    logic [PW-1:0]   r_wr_pos;

    // config
    t_sample         r_thr [THR_N];
    t_reg_idx        w_idx;

    // stage A: ring read
    logic            r_a_valid;
    t_sample         r_a_old;
    logic            r_a_oldv;
    t_sample         r_a_sample;
    // stage B: running sum
    logic [SW-1:0]   r_sum;
    logic [SW-1:0]   n_sum;
    logic            r_b_valid;
    logic [SW-1:0]   r_b_sum;
    // stage C: reciprocal product
    logic            r_c_valid;
    logic [PRW-1:0]  r_c_prod;
    // output register
    logic            r_o_valid;
    t_sample         r_o_average;
    t_level          r_o_level;

    logic            w_out_rdy, w_c_rdy, w_b_rdy, w_a_rdy;
    logic            w_acc, w_a_mv;
    t_sample         w_avg;
    t_level          w_level;
    t_sample         w_old;

    assign w_out_rdy = !r_o_valid || i_ready;
    assign w_c_rdy   = !r_c_valid || w_out_rdy;
    assign w_b_rdy   = !r_b_valid || w_c_rdy;
    assign w_a_rdy   = !r_a_valid || w_b_rdy;
    assign w_acc     = i_valid && w_a_rdy;
    assign w_a_mv    = r_a_valid && w_b_rdy;

    assign o_ready   = w_a_rdy;
    assign o_valid   = r_o_valid;
    assign o_average = r_o_average;
    assign o_level   = r_o_level;

    // APB
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign prdata = DATA_W'(r_thr[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[REG_THR1] <= THR1_RST;
            r_thr[REG_THR2] <= THR2_RST;
            r_thr[REG_THR3] <= THR3_RST;
            r_thr[REG_THR4] <= THR4_RST;
        end else if (psel && penable && pwrite && pready) begin
            r_thr[w_idx] <= pwdata[SAMPLE_W-1:0];
        end
    end

    // ring memory: read-first, old entry out while the new sample goes in
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ring[r_wr_pos] <= i_sample;
            r_a_old          <= r_ring[r_wr_pos];
            r_a_sample       <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_wr_pos   <= '0;
            r_a_oldv   <= 1'b0;
        end else if (w_acc) begin
            r_ring_vld[r_wr_pos] <= 1'b1;
            r_a_oldv             <= r_ring_vld[r_wr_pos];
            r_wr_pos             <= (r_wr_pos == POS_LAST) ? '0 : r_wr_pos + 1'b1;
        end
    end

    assign w_old = r_a_oldv ? r_a_old : '0;
    assign n_sum = r_sum + SW'(r_a_sample) - SW'(w_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_a_mv) begin
            r_sum <= n_sum;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_a_mv) begin
            r_b_sum <= n_sum;
        end
        if (r_b_valid && w_c_rdy) begin
            r_c_prod <= PRW'(r_b_sum) * PRW'(W_RECIP);
        end
        if (r_c_valid && w_out_rdy) begin
            r_o_average <= w_avg;
            r_o_level   <= w_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_a_rdy)   r_a_valid <= w_acc;
            if (w_b_rdy)   r_b_valid <= r_a_valid;
            if (w_c_rdy)   r_c_valid <= r_b_valid;
            if (w_out_rdy) r_o_valid <= r_c_valid;
        end
    end

    assign w_avg = SAMPLE_W'(r_c_prod >> KSH);

    // first threshold the average lies below wins
    always_comb begin
        w_level = LEVEL_NONE;
        for (int k = THR_N - 1; k >= 0; k--) begin
            if (w_avg < r_thr[k]) w_level = LEVEL_W'(k);
        end
    end

endmodule

### rtl/core/malc_checker.sv
// ----------------------------------------------------------------------------
// malc_checker
// Port-level checks for the moving average level classifier, bound to the
// top level.
// ----------------------------------------------------------------------------
module malc_checker
    import malc_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input logic [11:0]   o_average,
    input logic [2:0]    o_level
);

    // result register empty means every stage can take a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= LEVEL_NONE))
        else $error("level out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average) && $stable(o_level))
        else $error("stalled result changed");

    // an input transfer must pass every pipeline stage before it reaches the output
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid && o_ready) && !$past(i_valid && o_ready, 2)
            && !$past(i_valid && o_ready, 3) && !$past(o_valid) |=> !o_valid
            || $past(i_valid && o_ready, 3))
        else $error("result without matching input");

endmodule

bind moving_average_level_classifier malc_checker u_malc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_average (o_average),
    .o_level   (o_level)
);

### bench/malc_result_checker.sv
// ----------------------------------------------------------------------------
// malc_result_checker
// Watches the sample, result and register channels of the moving average
// level classifier. Keeps its own ring, running sum and thresholds, works
// out the average and level of every sample transfer and compares each
// result transfer against the oldest outstanding expectation. Register
// reads are checked against the thresholds held here.
// ----------------------------------------------------------------------------
module malc_result_checker
    import malc_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_sample           i_sample,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_sample           i_average,
    input  t_level            i_level,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results,
    output logic [4:0]        o_levels_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int PRINT_CAP = 30;

    typedef struct packed {
        t_sample average;
        t_level  level;
    } t_avg_level;

    t_sample          ring [WINDOW];
    int               wr_pos;
    logic [SUM_W-1:0] win_sum;
    t_sample          thr [THR_N];
    t_avg_level       avg_level_q [$];
    int               fail_cnt;
    int               result_cnt;
    logic [4:0]       levels_seen;

    assign o_fail_count  = fail_cnt;
    assign o_results     = result_cnt;
    assign o_levels_seen = levels_seen;

    task automatic report_failure(input string msg);
        if (fail_cnt < PRINT_CAP)
            $display("[%0t] FAIL: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // first threshold the average lies strictly below, in register order
    function automatic t_level level_of(input t_sample avg);
        for (int k = 0; k < THR_N; k++)
            if (avg < thr[k])
                return t_level'(k);
        return LEVEL_NONE;
    endfunction

    function automatic t_avg_level boxcar_update(input t_sample s);
        t_avg_level r;
        win_sum = win_sum - SUM_W'(ring[wr_pos]) + SUM_W'(s);
        ring[wr_pos] = s;
        wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
        r.average = t_sample'(win_sum / WINDOW);
        r.level   = level_of(r.average);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_avg_level head;
        if (!i_rst_n) begin
            foreach (ring[k])
                ring[k] = '0;
            wr_pos  = 0;
            win_sum = '0;
            thr[REG_THR1] = THR1_RST;
            thr[REG_THR2] = THR2_RST;
            thr[REG_THR3] = THR3_RST;
            thr[REG_THR4] = THR4_RST;
            avg_level_q.delete();
            o_pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite)
                    thr[paddr[ADDR_W-1:2]] = pwdata[SAMPLE_W-1:0];
                else if (prdata !== DATA_W'(thr[paddr[ADDR_W-1:2]]))
                    report_failure($sformatf("readback at 0x%0h: got 0x%0h, expected 0x%0h",
                                             paddr, prdata, thr[paddr[ADDR_W-1:2]]));
            end
            if (i_in_valid && i_in_ready)
                avg_level_q.push_back(boxcar_update(i_sample));
            if (i_out_valid && i_out_ready) begin
                if (avg_level_q.size() == 0) begin
                    report_failure($sformatf("result transfer with nothing outstanding: avg %0d lvl %0d",
                                             i_average, i_level));
                end else begin
                    head = avg_level_q.pop_front();
                    result_cnt++;
                    levels_seen[head.level] = 1'b1;
                    if (i_average !== head.average)
                        report_failure($sformatf("result %0d average: got %0d, expected %0d",
                                                 result_cnt, i_average, head.average));
                    if (i_level !== head.level)
                        report_failure($sformatf("result %0d level: got %0d, expected %0d",
                                                 result_cnt, i_level, head.level));
                end
            end
            o_pending <= avg_level_q.size();
        end
    end

    initial begin
        fail_cnt    = 0;
        result_cnt  = 0;
        levels_seen = '0;
    end

endmodule

### bench/moving_average_level_classifier_tb.sv
// ----------------------------------------------------------------------------
// moving_average_level_classifier_tb
// Drives samples and threshold settings into the classifier with random
// idling on both channels and long output hold-offs, and lets the checker
// compare every average and level. Reports the verdict at the end.
// ----------------------------------------------------------------------------
module moving_average_level_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import malc_pkg::*;

    localparam int ITEMS_PER_PHASE = 275;
    localparam int N_PHASES        = 6;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    t_sample           i_sample = '0;
    logic              i_ready = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;

    logic              o_ready;
    logic              o_valid;
    t_sample           o_average;
    t_level            o_level;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                results;
    logic [4:0]        levels_seen;

    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                hold_req    = 0;
    int                hold_seen   = 0;
    int                hold_left   = 0;
    int                cycle_count = 0;
    int                samples_sent = 0;
    t_sample           thr_now [THR_N];

    always #1 i_clk = ~i_clk;

    moving_average_level_classifier #(
        .WINDOW (DEF_WINDOW)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average),
        .o_level   (o_level),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    malc_result_checker #(
        .WINDOW (DEF_WINDOW)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_sample      (i_sample),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_average     (o_average),
        .i_level       (o_level),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_levels_seen (levels_seen)
    );

    // result side: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input t_reg_idx idx, input t_sample value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        // upper bits are noise; only the low 12 bits should land
        pwdata  <= wr ? ((DATA_W'($urandom()) & ~DATA_W'(SAMPLE_MAX)) | DATA_W'(value))
                      : DATA_W'($urandom());
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_thresholds(input t_sample t1, t2, t3, t4);
        thr_now = '{t1, t2, t3, t4};
        apb_access(1'b1, REG_THR1, t1);
        apb_access(1'b1, REG_THR2, t2);
        apb_access(1'b1, REG_THR3, t3);
        apb_access(1'b1, REG_THR4, t4);
    endtask

    task automatic read_thresholds();
        apb_access(1'b0, REG_THR1, '0);
        apb_access(1'b0, REG_THR2, '0);
        apb_access(1'b0, REG_THR3, '0);
        apb_access(1'b0, REG_THR4, '0);
    endtask

    task automatic send_sample(input t_sample s);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return t_sample'(SAMPLE_MAX);
        return t_sample'(v);
    endfunction

    // mostly settled runs, half near a threshold so the average lands on, just
    // under or over it, half elsewhere; the rest is raw noise and rail values
    task automatic random_stream(input int count);
        int sent;
        int run_len;
        int kind;
        int centre;
        int spread;
        int n;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                run_len = $urandom_range(16, 40);
                case ($urandom_range(3))
                    0, 1: centre = int'(thr_now[$urandom_range(THR_N - 1)])
                                   + int'($urandom_range(2)) - 1;
                    2:    centre = $urandom_range(SAMPLE_MAX);
                    default: centre = $urandom_range(1) ? SAMPLE_MAX : 0;
                endcase
                spread = $urandom_range(1) ? 0 : $urandom_range(8);
            end else if (kind < 85) begin
                run_len = $urandom_range(1, 20);
            end else begin
                run_len = $urandom_range(1, 8);
            end
            if (run_len > count - sent)
                run_len = count - sent;
            for (n = 0; n < run_len; n++) begin
                if (kind < 55)
                    send_sample(clamp_sample(centre + int'($urandom_range(2 * spread)) - spread));
                else if (kind < 85)
                    send_sample(t_sample'($urandom()));
                else
                    send_sample($urandom_range(1) ? t_sample'(SAMPLE_MAX) : t_sample'(0));
            end
            sent += run_len;
        end
    endtask

    initial begin
        int ph;
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds, start-up with zeros in the ring, rails and
        // alternating bit patterns, a full window at the top rail, then zeros
        thr_now = '{THR1_RST, THR2_RST, THR3_RST, THR4_RST};
        read_thresholds();
        tx_idle_pct = 22;
        rx_idle_pct = 82;
        send_sample('0);
        send_sample(t_sample'(SAMPLE_MAX));
        send_sample(12'hAAA);
        send_sample(12'h555);
        for (k = 0; k < DEF_WINDOW; k++)
            send_sample(t_sample'(SAMPLE_MAX));
        for (k = 0; k < 5; k++)
            send_sample('0);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++) begin
            tx_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 82 : 0;
            rx_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 22 : 0;
            case (ph)
                0: program_thresholds('0, '0, '0, '0);
                1: program_thresholds(t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX),
                                      t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MAX));
                2: program_thresholds(12'd3000, 12'd1000, 12'd2000, 12'd500);
                3: program_thresholds(12'd1900, 12'd2000, 12'd2100, 12'd2200);
                4: program_thresholds(t_sample'($urandom()), t_sample'($urandom()),
                                      t_sample'($urandom()), t_sample'($urandom()));
                default: program_thresholds(THR1_RST, THR2_RST, THR3_RST, THR4_RST);
            endcase
            read_thresholds();
            // block the result side long enough to back the pipe up to the input
            if (ph == 1 || ph == 4)
                hold_req <= hold_req + 1;
            random_stream(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("Run: %0d samples in, %0d results checked across %0d threshold settings",
                 samples_sent, results, N_PHASES + 1);
        $display("Levels seen (bit per level 4..0): %b; two long output hold-offs applied",
                 levels_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### moving_average_level_classifier.f
rtl/core/malc_pkg.sv
rtl/core/moving_average_level_classifier.sv
rtl/core/malc_checker.sv
bench/malc_result_checker.sv
bench/moving_average_level_classifier_tb.sv
